/* sv/plenum_pressure_throttle_step_core_defines.svh */
// ----------------------------------------------------------------------------
// Plenum throttle step assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PLENUM_PRESSURE_THROTTLE_STEP_CORE_DEFINES_SVH
`define PLENUM_PRESSURE_THROTTLE_STEP_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while dis is high.
`define PPTS_ASSERT_NOW(lbl, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, disabled while dis is high.
`define PPTS_ASSERT_NEXT(lbl, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ppts_pkg.sv */
// ----------------------------------------------------------------------------
// Plenum throttle step package
// Payload types, register indexes and reset constants.
// ----------------------------------------------------------------------------
package ppts_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CFG_INDEX_W = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_PRESSURE_GAIN       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_AMBIENT_PRESSURE    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_THROTTLE_INVERSE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_PRESSURE    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_OUTLET_FLOW = 3'd4;

  // Reset values.
  localparam logic [DATA_W-1:0] RST_PRESSURE_GAIN       = 32'd65536;
  localparam logic [DATA_W-1:0] RST_AMBIENT_PRESSURE    = 32'd25939200;
  localparam logic [DATA_W-1:0] RST_THROTTLE_INVERSE    = 32'd16777216;
  localparam logic [DATA_W-1:0] RST_INITIAL_PRESSURE    = 32'd25939200;
  localparam logic [DATA_W-1:0] RST_INITIAL_OUTLET_FLOW = 32'd0;

  localparam logic [DATA_W-1:0] PRESSURE_MAX = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] FLOW_MAX     = 32'h7FFF_FFFF;

  // Input command codes.
  localparam logic CMD_STEP    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic signed [DATA_W-1:0] inlet_flow;
  } in_t;

  typedef struct packed {
    logic        [DATA_W-1:0] plenum_pressure;
    logic signed [DATA_W-1:0] outlet_flow;
    logic                     saturated;
  } out_t;

endpackage

/* sv/ppts_mul.sv */
// ----------------------------------------------------------------------------
// Plenum throttle step multiplier
// Registered 32 x 32 unsigned multiplier shared by both products of a step.
// ----------------------------------------------------------------------------
module ppts_mul (
  input  logic                            clk,
  input  logic [ppts_pkg::DATA_W-1:0]     a,
  input  logic [ppts_pkg::DATA_W-1:0]     b,
  output logic [2*ppts_pkg::DATA_W-1:0]   prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

/* sv/ppts_sqrt.sv */
// ----------------------------------------------------------------------------
// Plenum throttle step square root
// Bitwise integer square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module ppts_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [2*ppts_pkg::DATA_W-1:0] radicand,
  output logic                          done,
  output logic [ppts_pkg::DATA_W-1:0]   root
);

  localparam int unsigned REM_W = ppts_pkg::DATA_W + 2;

  logic [2*ppts_pkg::DATA_W-1:0] rad;
  logic [REM_W-1:0]              rem;
  logic [4:0]                    cnt;
  logic                          busy;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  // Bring down the next two radicand bits and try root*4+1.
  assign rem_sh = {rem[REM_W-3:0], rad[2*ppts_pkg::DATA_W-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == 5'd0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= 5'd31;
    end else if (busy) begin
      rad  <= {rad[2*ppts_pkg::DATA_W-3:0], 2'b00};
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[ppts_pkg::DATA_W-2:0], fits};
      cnt  <= cnt - 5'd1;
    end
  end

endmodule

/* sv/plenum_pressure_throttle_step_core.sv */
// ----------------------------------------------------------------------------
// Plenum pressure throttle step core
// One explicit time step of a compressor plenum with a throttle, fixed point.
// ----------------------------------------------------------------------------
//
//   Channel | Dir | Handshake            | Payload
//   --------+-----+----------------------+-------------------------------------
//   in      | in  | in_valid / in_ready  | in_data  (cmd, inlet_flow)
//   out     | out | out_valid / out_ready| out_data (plenum_pressure,
//           |     |                      |           outlet_flow, saturated)
//   cfg     | in  | cfg_en (no wait)     | cfg_index, cfg_data
//
// An advance step with a positive pressure excess runs the multiplier twice and
// then the bitwise square root before its result is loaded. A step whose
// excess is not positive skips the throttle product and the root, and a
// restart goes straight to its result; each holds the block until its result
// is loaded into the output register.
// The block takes one item at a time; in_ready is high only while it is idle.
// The output register lets a new item start while the last result still waits;
// a finished step waits in its last state if that register is still occupied.
// Synchronous reset restores the configuration, sequencer, out_valid and stored state.
//
module plenum_pressure_throttle_step_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ppts_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ppts_pkg::out_t                     out_data,
  input  logic                               cfg_en,
  input  logic [ppts_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ppts_pkg::DATA_W-1:0]        cfg_data
);

  localparam int unsigned W = ppts_pkg::DATA_W;

  // One-hot sequencer. The multiplier is used in MUL_FLOW for the pressure
  // change and in MUL_EXC for the throttle product.
  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_MUL_FLOW  = 8'b0000_0010,
    S_ADD       = 8'b0000_0100,
    S_CMP       = 8'b0000_1000,
    S_MUL_EXC   = 8'b0001_0000,
    S_SQRT_GO   = 8'b0010_0000,
    S_SQRT_WAIT = 8'b0100_0000,
    S_DONE      = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration registers.
  logic [W-1:0] pressure_gain;
  logic [W-1:0] ambient_pressure;
  logic [W-1:0] throttle_inverse;
  logic [W-1:0] initial_pressure;
  logic [W-1:0] initial_outlet_flow;

  // Stored model state.
  logic [W-1:0] pressure_now;
  logic [W-1:0] outflow_now;

  // Working registers of one step.
  logic [W-1:0] mag;
  logic         neg;
  logic [W-1:0] excess;
  logic         sat;

  logic            in_xfer;
  logic            out_load;
  logic [W:0]      diff;
  logic [W:0]      diff_abs;
  logic [W-1:0]    mul_a;
  logic [W-1:0]    mul_b;
  logic [2*W-1:0]  prod;
  logic [2*W:0]    rounded;
  logic [W+7:0]    change;
  logic [W+8:0]    p_sum;
  logic [W-1:0]    p_new;
  logic            p_sat;
  logic            sq_start;
  logic            sq_done;
  logic [W-1:0]    sq_root;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);
  assign sq_start = (state == S_SQRT_GO);

  // Flow difference is exact in 33 bits; its magnitude never exceeds 2^32-1.
  assign diff     = {in_data.inlet_flow[W-1], in_data.inlet_flow}
                  - {outflow_now[W-1], outflow_now};
  assign diff_abs = diff[W] ? (~diff + 1'b1) : diff;

  assign mul_a = (state == S_MUL_FLOW) ? mag : excess;
  assign mul_b = (state == S_MUL_FLOW) ? pressure_gain : throttle_inverse;

  ppts_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  ppts_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (prod),
    .done     (sq_done),
    .root     (sq_root)
  );

  // The product carries 32 fraction bits; rounding to 8 fraction bits adds
  // half an LSB and drops 24 bits, so ties round away from zero.
  assign rounded = {1'b0, prod} + ((2*W+1)'(1) << 23);
  assign change  = rounded[2*W-1:24];

  always_comb begin
    if (neg) begin
      p_sum = {9'd0, pressure_now} - {1'b0, change};
    end else begin
      p_sum = {9'd0, pressure_now} + {1'b0, change};
    end
    p_sat = 1'b0;
    p_new = p_sum[W-1:0];
    if (neg && p_sum[W+8]) begin
      p_new = '0;
      p_sat = 1'b1;
    end else if (!neg && (p_sum[W+8:W] != 9'd0)) begin
      p_new = ppts_pkg::PRESSURE_MAX;
      p_sat = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_data.cmd == ppts_pkg::CMD_RESTART) begin
            state_next = S_DONE;
          end else begin
            state_next = S_MUL_FLOW;
          end
        end
      end
      S_MUL_FLOW:  state_next = S_ADD;
      S_ADD:       state_next = S_CMP;
      S_CMP: begin
        if (pressure_now > ambient_pressure) begin
          state_next = S_MUL_EXC;
        end else begin
          state_next = S_DONE;
        end
      end
      S_MUL_EXC:   state_next = S_SQRT_GO;
      S_SQRT_GO:   state_next = S_SQRT_WAIT;
      S_SQRT_WAIT: begin
        if (sq_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes; indexes past the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_gain       <= ppts_pkg::RST_PRESSURE_GAIN;
      ambient_pressure    <= ppts_pkg::RST_AMBIENT_PRESSURE;
      throttle_inverse    <= ppts_pkg::RST_THROTTLE_INVERSE;
      initial_pressure    <= ppts_pkg::RST_INITIAL_PRESSURE;
      initial_outlet_flow <= ppts_pkg::RST_INITIAL_OUTLET_FLOW;
    end else if (cfg_en) begin
      unique case (cfg_index)
        ppts_pkg::CFG_PRESSURE_GAIN:       pressure_gain       <= cfg_data;
        ppts_pkg::CFG_AMBIENT_PRESSURE:    ambient_pressure    <= cfg_data;
        ppts_pkg::CFG_THROTTLE_INVERSE:    throttle_inverse    <= cfg_data;
        ppts_pkg::CFG_INITIAL_PRESSURE:    initial_pressure    <= cfg_data;
        ppts_pkg::CFG_INITIAL_OUTLET_FLOW: initial_outlet_flow <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stored pressure and outlet flow.
  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_now <= ppts_pkg::RST_INITIAL_PRESSURE;
      outflow_now  <= '0;
    end else begin
      if (in_xfer && (in_data.cmd == ppts_pkg::CMD_RESTART)) begin
        pressure_now <= initial_pressure;
        outflow_now  <= initial_outlet_flow;
      end else if (state == S_ADD) begin
        pressure_now <= p_new;
      end else if ((state == S_CMP) && !(pressure_now > ambient_pressure)) begin
        outflow_now <= '0;
      end else if ((state == S_SQRT_WAIT) && sq_done) begin
        // A root with the top bit set does not fit the signed flow format.
        outflow_now <= sq_root[W-1] ? ppts_pkg::FLOW_MAX : sq_root;
      end
    end
  end

  // Step working registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mag <= diff_abs[W-1:0];
      neg <= diff[W];
      sat <= 1'b0;
    end else if (state == S_ADD) begin
      sat <= p_sat;
    end else if ((state == S_SQRT_WAIT) && sq_done && sq_root[W-1]) begin
      sat <= 1'b1;
    end
    if (state == S_CMP) begin
      excess <= pressure_now - ambient_pressure;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.plenum_pressure <= pressure_now;
      out_data.outlet_flow     <= outflow_now;
      out_data.saturated       <= sat;
    end
  end

endmodule

/* sv/ppts_checker.sv */
// ----------------------------------------------------------------------------
// Plenum throttle step port checker
// Port-level checks of the step core, attached to it by bind.
// ----------------------------------------------------------------------------
`include "plenum_pressure_throttle_step_core_defines.svh"

module ppts_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input ppts_pkg::out_t out_data
);

  `PPTS_ASSERT_NEXT(a_reset_idle, 1'b0, rst, in_ready && !out_valid, "not idle after reset")

  `PPTS_ASSERT_NEXT(a_busy_after_xfer, rst, in_valid && in_ready, !in_ready, "ready after transfer")

  `PPTS_ASSERT_NEXT(a_out_hold, rst, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")

  `PPTS_ASSERT_NOW(a_flow_clamp, rst, out_valid && out_data.saturated && (out_data.plenum_pressure != 32'd0) && (out_data.plenum_pressure != ppts_pkg::PRESSURE_MAX), out_data.outlet_flow == ppts_pkg::FLOW_MAX, "saturation without clamp")

endmodule

bind plenum_pressure_throttle_step_core ppts_checker u_ppts_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Plenum throttle step core testbench
// Sends advance and restart items through the valid/ready input, predicts each
// result with a bit-accurate plenum model kept in step with the register
// writes, and compares every output transfer field by field, under random
// sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CLK_HALF     = 10;
  // The slowest correct run is about 800 items at the slowest step, each with
  // the longest sender gap and receiver stall, plus one long hold-off. The
  // limit is several times that.
  localparam int LIMIT_CYCLES = 600000;
  localparam int REPORT_MAX   = 10;
  // The tail wait after the last result is comfortably longer than a step with
  // a positive pressure excess.
  localparam int TAIL_CYCLES  = 60;
  localparam int PHASE_ITEMS  = 95;
  localparam int PHASE_COUNT  = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int PRESS_ITEMS  = 24;

  // Half of one LSB of the Q.8 pressure, seen through a gain of one LSB: the
  // rounding tie point of the pressure update.
  localparam logic signed [31:0] ROUND_TIE = 32'sh0080_0000;
  localparam logic signed [31:0] ONE_FLOW  = 32'sh0001_0000;
  localparam logic signed [31:0] FLOW_MIN  = 32'sh8000_0000;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_PATTERN, RX_SLUMP} rx_mode_t;

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             in_valid  = 1'b0;
  logic                             in_ready;
  ppts_pkg::in_t                    in_data   = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  ppts_pkg::out_t                   out_data;
  logic                             cfg_en    = 1'b0;
  logic [ppts_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ppts_pkg::DATA_W-1:0]      cfg_data  = '0;

  // Our copy of the registers and of the plenum state.
  logic [31:0]        gain_q;
  logic [31:0]        ambient_q;
  logic [31:0]        throttle_q;
  logic [31:0]        p0_q;
  logic signed [31:0] f0_q;
  logic [31:0]        plenum_p;
  logic signed [31:0] throttle_flow;

  // Predicted results, oldest first.
  ppts_pkg::out_t pending_results[$];

  int n_sent     = 0;
  int n_steps    = 0;
  int n_restarts = 0;
  int n_checked  = 0;
  int n_clamped  = 0;
  int n_errors   = 0;
  int n_reported = 0;
  int n_settings = 0;
  int cycles     = 0;

  // Sender burst control.
  int burst_left    = 1;
  bit sender_steady = 1'b0;

  // Receiver control. The test side bumps hold_req to ask for one long
  // hold-off; the receiver process counts the cycles itself.
  rx_mode_t    rx_mode    = RX_ALWAYS;
  int          hold_req   = 0;
  int          hold_seen  = 0;
  int          hold_left  = 0;
  logic [15:0] rx_pattern = 16'hB5A3;
  int          rx_turns   = 0;
  int          slump_left = 0;

  plenum_pressure_throttle_step_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Integer square root, rounded down, by the bit-pair method.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] b;
    rem  = n;
    root = '0;
    b    = 64'h4000_0000_0000_0000;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // Applies one item to the plenum state and returns the result it produces.
  function automatic ppts_pkg::out_t advance_plenum(input ppts_pkg::in_t item);
    ppts_pkg::out_t     res;
    logic signed [33:0] diff;
    logic               neg;
    logic [32:0]        mag;
    logic [64:0]        prod;
    logic [40:0]        delta;
    logic signed [43:0] p_next;
    logic [63:0]        excess;
    logic [63:0]        root;
    res = '0;
    if (item.cmd == ppts_pkg::CMD_RESTART) begin
      plenum_p      = p0_q;
      throttle_flow = f0_q;
    end else begin
      // The flow difference is exact in 34 bits; the pressure change is the
      // magnitude times the gain, rounded half away from zero to Q.8.
      diff  = item.inlet_flow - throttle_flow;
      neg   = diff[33];
      mag   = neg ? 33'(-diff) : 33'(diff);
      prod  = mag * gain_q;
      delta = 41'((prod + 65'd8388608) >> 24);
      p_next = $signed({12'd0, plenum_p});
      if (neg) begin
        p_next = p_next - $signed({3'd0, delta});
      end else begin
        p_next = p_next + $signed({3'd0, delta});
      end
      if (p_next < 0) begin
        plenum_p      = '0;
        res.saturated = 1'b1;
      end else if (p_next > $signed({12'd0, ppts_pkg::PRESSURE_MAX})) begin
        plenum_p      = ppts_pkg::PRESSURE_MAX;
        res.saturated = 1'b1;
      end else begin
        plenum_p = p_next[31:0];
      end
      // The throttle only passes flow while the plenum is above ambient.
      if (plenum_p > ambient_q) begin
        excess = {32'd0, plenum_p - ambient_q};
        root   = floor_sqrt(excess * {32'd0, throttle_q});
        if (root > {32'd0, ppts_pkg::FLOW_MAX}) begin
          throttle_flow = ppts_pkg::FLOW_MAX;
          res.saturated = 1'b1;
        end else begin
          throttle_flow = root[31:0];
        end
      end else begin
        throttle_flow = '0;
      end
    end
    res.plenum_pressure = plenum_p;
    res.outlet_flow     = throttle_flow;
    return res;
  endfunction

  // Follows register writes and input transfers as the block sees them, so
  // the prediction is made in the same order as the hardware works.
  always @(posedge clk) begin
    if (rst) begin
      gain_q        = ppts_pkg::RST_PRESSURE_GAIN;
      ambient_q     = ppts_pkg::RST_AMBIENT_PRESSURE;
      throttle_q    = ppts_pkg::RST_THROTTLE_INVERSE;
      p0_q          = ppts_pkg::RST_INITIAL_PRESSURE;
      f0_q          = ppts_pkg::RST_INITIAL_OUTLET_FLOW;
      plenum_p      = ppts_pkg::RST_INITIAL_PRESSURE;
      throttle_flow = '0;
      pending_results.delete();
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          ppts_pkg::CFG_PRESSURE_GAIN:       gain_q     = cfg_data;
          ppts_pkg::CFG_AMBIENT_PRESSURE:    ambient_q  = cfg_data;
          ppts_pkg::CFG_THROTTLE_INVERSE:    throttle_q = cfg_data;
          ppts_pkg::CFG_INITIAL_PRESSURE:    p0_q       = cfg_data;
          ppts_pkg::CFG_INITIAL_OUTLET_FLOW: f0_q       = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        pending_results.insert(pending_results.size(), advance_plenum(in_data));
      end
    end
  end

  // Compares each output transfer with the oldest prediction.
  always @(posedge clk) begin
    ppts_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      n_checked++;
      if (out_data.saturated) n_clamped++;
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_reported < REPORT_MAX) begin
          n_reported++;
          $display("result %0d arrived with nothing predicted: %s %h flow %h clamp %b",
                   n_checked, "pressure", out_data.plenum_pressure,
                   out_data.outlet_flow, out_data.saturated);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_data.plenum_pressure !== want.plenum_pressure ||
            out_data.outlet_flow !== want.outlet_flow ||
            out_data.saturated !== want.saturated) begin
          n_errors++;
          if (n_reported < REPORT_MAX) begin
            n_reported++;
            $display("result %0d mismatch: pressure exp %h got %h, flow exp %h got %h,",
                     n_checked, want.plenum_pressure, out_data.plenum_pressure,
                     want.outlet_flow, out_data.outlet_flow);
            $display("  clamp exp %b got %b", want.saturated, out_data.saturated);
          end
        end
      end
    end
  end

  // Receiver: one long hold-off on request, otherwise the current stall mode.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
        RX_PATTERN: begin
          // A rotating 16-bit mask, swapped for a fresh one every few turns.
          out_ready <= rx_pattern[0];
          rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
          rx_turns++;
          if (rx_turns == 48) begin
            rx_turns   = 0;
            rx_pattern = 16'($urandom()) | 16'h0001;
          end
        end
        default: begin
          // Mostly ready, with occasional stalls that can outlast a whole step.
          if (slump_left > 0) begin
            slump_left--;
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 11) == 0) slump_left = $urandom_range(1, 60);
          end
        end
      endcase
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles: %0d sent, %0d results checked",
               cycles, n_sent, n_checked);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Offers one item and returns right after the edge of its transfer. Valid
  // stays high on return unless a gap was taken, so the caller either sends
  // the next item at once or lowers valid in that same time step.
  task automatic send_item(input ppts_pkg::in_t item);
    int gap;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    if (item.cmd == ppts_pkg::CMD_RESTART) n_restarts++;
    else n_steps++;
    if (!sender_steady) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        // Mostly short gaps; some long enough to land anywhere in a step.
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 45) : $urandom_range(0, 4);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  task automatic send_advance(input logic signed [31:0] flow);
    ppts_pkg::in_t item;
    item.cmd        = ppts_pkg::CMD_STEP;
    item.inlet_flow = flow;
    send_item(item);
  endtask

  // The inlet flow of a restart is ignored, so it carries random bits.
  task automatic send_restart();
    ppts_pkg::in_t item;
    item.cmd        = ppts_pkg::CMD_RESTART;
    item.inlet_flow = $urandom();
    send_item(item);
  endtask

  // Stops offering and waits until every transfer so far has its result.
  task automatic drain();
    in_valid <= 1'b0;
    while (n_checked < n_sent) @(posedge clk);
  endtask

  // Drives one write; the caller lowers the enable after its last write.
  task automatic write_reg(input logic [ppts_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [31:0] val);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [31:0] gain, input logic [31:0] ambient,
                               input logic [31:0] throttle, input logic [31:0] p0,
                               input logic [31:0] f0);
    drain();
    write_reg(ppts_pkg::CFG_PRESSURE_GAIN, gain);
    write_reg(ppts_pkg::CFG_AMBIENT_PRESSURE, ambient);
    write_reg(ppts_pkg::CFG_THROTTLE_INVERSE, throttle);
    write_reg(ppts_pkg::CFG_INITIAL_PRESSURE, p0);
    write_reg(ppts_pkg::CFG_INITIAL_OUTLET_FLOW, f0);
    cfg_en <= 1'b0;
    n_settings++;
  endtask

  // Inlet flow for random steps. Many values sit near the current outlet flow
  // so the plenum stays in its working range instead of pinning at a rail.
  function automatic logic signed [31:0] pick_inlet();
    int jitter;
    jitter = int'($urandom_range(0, 131072)) - 65536;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return throttle_flow + jitter;
      4, 5:       return int'($urandom_range(0, 1 << 22)) - (1 << 21);
      6, 7, 8:    return $urandom();
      default: begin
        case ($urandom_range(0, 3))
          0:       return ppts_pkg::FLOW_MAX;
          1:       return FLOW_MIN;
          2:       return '0;
          default: return throttle_flow;
        endcase
      end
    endcase
  endfunction

  // Reset values: a balanced plenum, one unit of flow in, a rounding tie on
  // the way down, a restart, then both inlet extremes.
  task automatic test_defaults();
    rx_mode = RX_ALWAYS;
    send_advance('0);
    send_advance(ONE_FLOW);
    send_advance(-(ROUND_TIE >>> 16));
    send_restart();
    send_advance(ppts_pkg::FLOW_MAX);
    send_advance(FLOW_MIN);
  endtask

  // Every register at a rail: pressure clamps at the top and at zero, and the
  // square root overflows the flow range.
  task automatic test_extremes();
    load_settings(ppts_pkg::PRESSURE_MAX, '0, ppts_pkg::PRESSURE_MAX,
                  ppts_pkg::PRESSURE_MAX, FLOW_MIN);
    send_restart();
    send_advance(ppts_pkg::FLOW_MAX);
    send_advance(FLOW_MIN);
    send_restart();
    send_advance(FLOW_MIN);
  endtask

  // A gain of one LSB, starting from zero pressure and with the plenum never
  // above ambient, so the outlet flow stays zero throughout.
  task automatic test_rounding();
    load_settings(32'd1, ppts_pkg::PRESSURE_MAX, '0, '0, '0);
    send_restart();
    send_advance(-ROUND_TIE);
    send_advance(ROUND_TIE);
    send_advance(ROUND_TIE - 1);
    send_advance(ROUND_TIE * 3);
    send_advance(-ROUND_TIE);
  endtask

  // Writes to unused indexes must leave every register alone. With zero gain
  // and zero throttle inverse, the pressure holds and each advance shows zero flow.
  task automatic test_ignored_writes();
    logic [ppts_pkg::CFG_INDEX_W-1:0] idx;
    load_settings('0, '0, '0, 32'h0000_1000, ONE_FLOW);
    @(posedge clk);
    for (int k = int'(ppts_pkg::CFG_INITIAL_OUTLET_FLOW) + 1;
         k < (1 << ppts_pkg::CFG_INDEX_W); k++) begin
      idx = k[ppts_pkg::CFG_INDEX_W-1:0];
      write_reg(idx, $urandom());
    end
    cfg_en <= 1'b0;
    send_restart();
    send_advance($urandom());
    send_advance($urandom());
  endtask

  // Several register settings, each followed by a run of random items, with the
  // receiver stepping through its stall modes from one setting to the next.
  task automatic test_random_settings();
    logic [31:0] gain;
    logic [31:0] ambient;
    logic [31:0] throttle;
    logic [31:0] p0;
    logic [31:0] f0;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph % 4)
        1: begin
          gain     = $urandom();
          ambient  = $urandom();
          throttle = $urandom();
          p0       = $urandom();
          f0       = $urandom();
        end
        2: begin
          // The two rails in turn.
          gain     = (ph < 4) ? ppts_pkg::PRESSURE_MAX : '0;
          ambient  = (ph < 4) ? '0 : ppts_pkg::PRESSURE_MAX;
          throttle = (ph < 4) ? ppts_pkg::PRESSURE_MAX : '0;
          p0       = (ph < 4) ? ppts_pkg::PRESSURE_MAX : '0;
          f0       = (ph < 4) ? ppts_pkg::FLOW_MAX : FLOW_MIN;
        end
        default: begin
          // Physically sensible values around atmospheric pressure.
          gain     = $urandom_range(1 << 10, 1 << 20);
          ambient  = $urandom_range(1 << 24, 1 << 27);
          throttle = $urandom_range(1 << 18, 1 << 26);
          p0       = ambient + $urandom_range(0, 1 << 16);
          f0       = $urandom_range(0, 1 << 20);
        end
      endcase
      load_settings(gain, ambient, throttle, p0, f0);
      rx_mode       = rx_mode_t'(ph % 4);
      sender_steady = (ph % 3 == 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 8) send_restart();
        else send_advance(pick_inlet());
      end
    end
    sender_steady = 1'b0;
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the
  // output register fills, the finished step behind it waits, and in_ready
  // stays low until the receiver lets go.
  task automatic test_backpressure();
    rx_mode       = RX_ALWAYS;
    sender_steady = 1'b1;
    hold_req++;
    for (int i = 0; i < PRESS_ITEMS; i++) begin
      if (i % 8 == 5) send_restart();
      else send_advance(pick_inlet());
    end
    sender_steady = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_defaults();
    test_extremes();
    test_rounding();
    test_ignored_writes();
    test_random_settings();
    test_backpressure();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    n_errors += pending_results.size();
    $display("testbench: %0d items (%0d steps, %0d restarts) under %0d register settings",
             n_sent, n_steps, n_restarts, n_settings);
    $display("testbench: %0d results compared, %0d clamped, %0d mismatches,",
             n_checked, n_clamped, n_errors);
    $display("testbench: one %0d-cycle receiver hold-off", HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
